// File: rtl/ibeq_pkg.sv
// ----------------------------------------------------------------------------
// ibeq_pkg
// Shared types and constants for the IIR band bank equalizer.
// ----------------------------------------------------------------------------
package ibeq_pkg;

  localparam int BAND_COUNT   = 10;
  localparam int NUM_TAPS     = 8;
  localparam int NUM_CHANNELS = 2;
  localparam int HIST_LEN     = NUM_TAPS - 1;

  localparam int BAND_W = (BAND_COUNT > 1) ? $clog2(BAND_COUNT) : 1;
  localparam int TAP_W  = $clog2(NUM_TAPS);
  localparam int CH_W   = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1;
  localparam int HIDX_W = (HIST_LEN > 1) ? $clog2(HIST_LEN) : 1;

  // band history memory: one row per channel and band, HIST_LEN words each
  localparam int YH_DEPTH = NUM_CHANNELS * BAND_COUNT * HIST_LEN;
  localparam int YH_AW    = $clog2(YH_DEPTH);
  // coefficient memory: band, feedback bit, tap
  localparam int CF_DEPTH = BAND_COUNT * 2 * NUM_TAPS;
  localparam int CF_AW    = $clog2(CF_DEPTH);
  // input history memory: channel, tap
  localparam int XH_DEPTH = NUM_CHANNELS * HIST_LEN;
  localparam int XH_AW    = (XH_DEPTH > 1) ? $clog2(XH_DEPTH) : 1;

  // clearing pass: coefficients in parallel with both history memories
  localparam int CLR_LEN = (CF_DEPTH > YH_DEPTH + XH_DEPTH) ? CF_DEPTH
                                                           : YH_DEPTH + XH_DEPTH;

  localparam int ACC_W = 72;

  localparam logic [15:0] UNITY_GAIN = 16'd4096;

  localparam logic [1:0] KIND_SAMPLE = 2'd0;
  localparam logic [1:0] KIND_COEF   = 2'd1;
  localparam logic [1:0] KIND_GAIN   = 2'd2;

  typedef enum logic [3:0] {
    ST_CLEAR, ST_IDLE, ST_B0, ST_TAP, ST_TAPY, ST_BEND, ST_BGAIN,
    ST_SHIFT, ST_SHIFTW, ST_OUT
  } ibeq_state_t;

  typedef struct packed {
    logic clr_step;    // write zero at clear index
    logic latch_in;    // capture input item
    logic do_cfg;      // apply coefficient or gain write
    logic acc_init;    // acc <= x*b0 term (b0 product in flight)
    logic rd_tap;      // issue reads for current tap
    logic mac_tap;     // accumulate tap products
    logic band_done;   // round/saturate band, start gain product
    logic gain_acc;    // add gain product to total
    logic shift_rd;    // read history entry for shift
    logic shift_wr;    // write shifted history entry
    logic out_load;    // load output register
    logic tap_next;
    logic band_next;
  } ibeq_cmd_t;

  typedef struct packed {
    logic clr_last;
    logic tap_last;
    logic band_last;
    logic shift_last;
    logic item_sample;  // latched item is a valid sample
  } ibeq_sts_t;

endpackage

// File: rtl/ibeq_ctrl.sv
// ----------------------------------------------------------------------------
// ibeq_ctrl
// Sequencer: clearing pass, per-band tap loop, history shift, output.
// ----------------------------------------------------------------------------
module ibeq_ctrl import ibeq_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_stall,
  input  logic      out_busy,
  input  ibeq_sts_t sts,
  output ibeq_cmd_t cmd
);

  ibeq_state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) state_r <= ST_CLEAR;
    else        state_r <= state_nxt;
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_CLEAR:  if (sts.clr_last) state_nxt = ST_IDLE;
      ST_IDLE:   if (in_valid) state_nxt = ST_B0;
      ST_B0:     state_nxt = sts.item_sample ? ST_TAP : ST_IDLE;
      ST_TAP:    state_nxt = ST_TAPY;
      ST_TAPY:   state_nxt = sts.tap_last ? ST_BEND : ST_TAP;
      ST_BEND:   state_nxt = ST_BGAIN;
      ST_BGAIN:  state_nxt = sts.band_last ? ST_SHIFT : ST_B0;
      ST_SHIFT:  state_nxt = ST_SHIFTW;
      ST_SHIFTW: state_nxt = sts.shift_last ? ST_OUT : ST_SHIFT;
      ST_OUT:    if (!out_busy) state_nxt = ST_IDLE;
      default:   state_nxt = ST_CLEAR;
    endcase
  end

  always_comb begin
    cmd = '0;
    in_stall = (state_r != ST_IDLE);
    case (state_r)
      ST_CLEAR:  cmd.clr_step = 1'b1;
      ST_IDLE:   cmd.latch_in = in_valid;
      ST_B0: begin
        cmd.do_cfg   = 1'b1;
        cmd.acc_init = 1'b1;
      end
      ST_TAP:    cmd.rd_tap = 1'b1;
      ST_TAPY: begin
        cmd.mac_tap  = 1'b1;
        cmd.tap_next = 1'b1;
      end
      ST_BEND:   cmd.band_done = 1'b1;
      ST_BGAIN: begin
        cmd.gain_acc  = 1'b1;
        cmd.band_next = 1'b1;
      end
      ST_SHIFT:  cmd.shift_rd = 1'b1;
      ST_SHIFTW: cmd.shift_wr = 1'b1;
      ST_OUT:    cmd.out_load = !out_busy;
      default:   cmd = '0;
    endcase
  end

endmodule

// File: rtl/ibeq_dp.sv
// ----------------------------------------------------------------------------
// ibeq_dp
// Datapath: coefficient, gain and history memories, one shared MAC, output
// register.
// ----------------------------------------------------------------------------
module ibeq_dp import ibeq_pkg::*; (
  input  logic               clk,
  input  logic               rst_n,
  input  ibeq_cmd_t          cmd,
  output ibeq_sts_t          sts,
  input  logic [1:0]         in_kind,
  input  logic [0:0]         in_channel,
  input  logic signed [15:0] in_sample,
  input  logic [3:0]         in_band,
  input  logic [2:0]         in_coef_index,
  input  logic [0:0]         in_coef_is_feedback,
  input  logic signed [23:0] in_coef_value,
  input  logic [15:0]        in_gain_value,
  input  logic               out_stall,
  output logic               out_valid,
  output logic signed [15:0] out_sample,
  output logic [0:0]         out_channel,
  output logic               out_clipped
);

  // latched item
  logic [1:0]         kind_r;
  logic [0:0]         ch_r;
  logic signed [15:0] x_r;
  logic [3:0]         wband_r;
  logic [2:0]         wtap_r;
  logic               wfb_r;
  logic signed [23:0] cval_r;
  logic [15:0]        gval_r;

  always_ff @(posedge clk) begin
    if (cmd.latch_in) begin
      kind_r  <= in_kind;
      ch_r    <= in_channel;
      x_r     <= in_sample;
      wband_r <= in_band;
      wtap_r  <= in_coef_index;
      wfb_r   <= in_coef_is_feedback;
      cval_r  <= in_coef_value;
      gval_r  <= in_gain_value;
    end
  end

  // loop counters
  logic [BAND_W-1:0] band_r;
  logic [TAP_W-1:0]  tap_r;     // tap k, runs 1..NUM_TAPS-1
  logic [HIDX_W-1:0] sh_r;      // shift index, counts down
  logic [BAND_W:0]   shb_r;     // shift row: BAND_COUNT bands plus input row
  logic [YH_AW:0]    clr_r;

  logic shift_row_last, shift_idx_last;
  assign shift_idx_last = (sh_r == '0);
  assign shift_row_last = (shb_r == (BAND_W+1)'(BAND_COUNT));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      band_r <= '0;
      tap_r  <= TAP_W'(1);
      clr_r  <= '0;
      sh_r   <= HIDX_W'(HIST_LEN - 1);
      shb_r  <= '0;
    end else begin
      if (cmd.clr_step) clr_r <= clr_r + 1'b1;
      if (cmd.tap_next) tap_r <= sts.tap_last ? TAP_W'(1) : tap_r + 1'b1;
      if (cmd.band_next)
        band_r <= sts.band_last ? '0 : band_r + 1'b1;
      if (cmd.shift_wr) begin
        if (shift_idx_last) begin
          sh_r  <= HIDX_W'(HIST_LEN - 1);
          shb_r <= shift_row_last ? '0 : shb_r + 1'b1;
        end else begin
          sh_r <= sh_r - 1'b1;
        end
      end
    end
  end

  assign sts.clr_last   = (clr_r == (YH_AW+1)'(CLR_LEN - 1));
  assign sts.tap_last   = (tap_r == TAP_W'(NUM_TAPS - 1));
  assign sts.band_last  = (band_r == BAND_W'(BAND_COUNT - 1));
  assign sts.shift_last = shift_idx_last && shift_row_last;
  assign sts.item_sample = (kind_r == KIND_SAMPLE) &&
                           ({31'd0, ch_r} < NUM_CHANNELS);

  // ---------------- memories ----------------
  logic signed [23:0] cf_mem [CF_DEPTH];
  logic signed [31:0] yh_mem [YH_DEPTH];
  logic signed [15:0] xh_mem [XH_DEPTH];
  logic [15:0]        gain_r [BAND_COUNT];

  logic cf_we;
  logic [CF_AW-1:0] cf_wa, cf_ra;
  logic signed [23:0] cf_wd;
  logic signed [23:0] cfb_q, cfa_q;   // two reads per tap via two read ports
  logic [CF_AW-1:0] cf_ra2;

  // coefficient writes; the clearing pass zeroes every entry first
  always_comb begin
    cf_we = cmd.do_cfg && (kind_r == KIND_COEF) &&
            ({28'd0, wband_r} < BAND_COUNT) && ({29'd0, wtap_r} < NUM_TAPS);
    cf_wa = CF_AW'((32'(wband_r) * 2 + 32'(wfb_r)) * NUM_TAPS + 32'(wtap_r));
    cf_wd = cval_r;
    if (cmd.clr_step) begin
      cf_we = (clr_r < (YH_AW+1)'(CF_DEPTH));
      cf_wa = clr_r[CF_AW-1:0];
      cf_wd = '0;
    end
  end

  // read addresses: b0 at ST_B0, b(k) and a(k) at ST_TAP
  always_comb begin
    if (cmd.acc_init) cf_ra = CF_AW'(32'(band_r) * 2 * NUM_TAPS);
    else              cf_ra = CF_AW'(32'(band_r) * 2 * NUM_TAPS + 32'(tap_r));
    cf_ra2 = CF_AW'((32'(band_r) * 2 + 1) * NUM_TAPS + 32'(tap_r));
  end

  always_ff @(posedge clk) begin
    if (cf_we) cf_mem[cf_wa] <= cf_wd;
    cfb_q <= cf_mem[cf_ra];
    cfa_q <= cf_mem[cf_ra2];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < BAND_COUNT; i++) gain_r[i] <= UNITY_GAIN;
    end else if (cmd.do_cfg && kind_r == KIND_GAIN &&
                 {28'd0, wband_r} < BAND_COUNT) begin
      gain_r[wband_r[BAND_W-1:0]] <= gval_r;
    end
  end

  // history addressing
  logic [YH_AW-1:0] yh_row, yh_ra, yh_wa;
  logic [XH_AW-1:0] xh_row, xh_ra, xh_wa;
  logic signed [31:0] yh_q, yh_wd;
  logic signed [15:0] xh_q, xh_wd;
  logic yh_we, xh_we;
  logic signed [31:0] yb_r [BAND_COUNT];  // this sample's band outputs

  assign yh_row = YH_AW'((32'(ch_r) * BAND_COUNT + 32'(band_r)) * HIST_LEN);
  assign xh_row = XH_AW'(32'(ch_r) * HIST_LEN);

  logic [YH_AW-1:0] sh_yrow;
  assign sh_yrow = YH_AW'((32'(ch_r) * BAND_COUNT + 32'(shb_r)) * HIST_LEN);

  logic shift_src_new;   // index 0 takes the new value
  assign shift_src_new = shift_idx_last;

  always_comb begin
    yh_ra = yh_row + YH_AW'(tap_r - 1'b1);
    xh_ra = xh_row + XH_AW'(tap_r - 1'b1);
    if (cmd.shift_rd || cmd.shift_wr) begin
      yh_ra = sh_yrow + YH_AW'(sh_r - 1'b1);
      xh_ra = xh_row + XH_AW'(sh_r - 1'b1);
    end
    yh_wa = sh_yrow + YH_AW'(sh_r);
    xh_wa = xh_row + XH_AW'(sh_r);
    yh_we = cmd.shift_wr && !shift_row_last;
    xh_we = cmd.shift_wr && shift_row_last;
    yh_wd = shift_src_new ? yb_r[shb_r[BAND_W-1:0]] : yh_q;
    xh_wd = shift_src_new ? x_r : xh_q;
    if (cmd.clr_step) begin
      yh_we = (clr_r < (YH_AW+1)'(YH_DEPTH));
      xh_we = (clr_r >= (YH_AW+1)'(YH_DEPTH)) &&
              (clr_r < (YH_AW+1)'(YH_DEPTH + XH_DEPTH));
      yh_wa = clr_r[YH_AW-1:0];
      xh_wa = XH_AW'(clr_r - (YH_AW+1)'(YH_DEPTH));
      yh_wd = '0;
      xh_wd = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (yh_we) yh_mem[yh_wa] <= yh_wd;
    if (xh_we) xh_mem[xh_wa] <= xh_wd;
    yh_q <= yh_mem[yh_ra];
    xh_q <= xh_mem[xh_ra];
  end

  // ---------------- shared MAC ----------------
  // b products are pipelined: ST_TAP reads, ST_TAPY multiplies/accumulates.
  logic signed [ACC_W-1:0] acc_r;
  logic b0_pend_r;

  logic signed [39:0] mul_xb;
  logic signed [55:0] mul_ya;
  assign mul_xb = xh_q * cfb_q;
  assign mul_ya = yh_q * cfa_q;

  logic signed [ACC_W-1:0] rnd;
  logic signed [ACC_W-21:0] yshift;
  logic signed [31:0] ysat;
  logic signed [47:0] gprod_r;
  logic signed [ACC_W-1:0] total_r;

  assign rnd    = acc_r + ACC_W'(1 << 19);
  assign yshift = rnd[ACC_W-1:20];
  always_comb begin
    if (yshift > 52'sd2147483647)       ysat = 32'sh7fffffff;
    else if (yshift < -52'sd2147483648) ysat = 32'sh80000000;
    else                                 ysat = yshift[31:0];
  end

  always_ff @(posedge clk) begin
    b0_pend_r <= cmd.acc_init;
    if (cmd.acc_init) acc_r <= '0;
    if (b0_pend_r) acc_r <= ACC_W'(x_r * cfb_q) <<< 8;
    if (cmd.mac_tap)
      acc_r <= acc_r + (ACC_W'(mul_xb) <<< 8) - ACC_W'(mul_ya);
    if (cmd.band_done) begin
      yb_r[band_r] <= ysat;
      gprod_r <= $signed({1'b0, gain_r[band_r]}) * ysat;
    end
    if (cmd.gain_acc) total_r <= total_r + ACC_W'(gprod_r);
    if (cmd.latch_in) total_r <= '0;
  end

  // ---------------- output ----------------
  logic signed [ACC_W-1:0] trnd;
  logic signed [ACC_W-21:0] tsh;
  logic signed [15:0] osat;
  logic oclip;
  assign trnd = total_r + ACC_W'(1 << 19);
  assign tsh  = trnd[ACC_W-1:20];
  always_comb begin
    oclip = 1'b1;
    if (tsh > 52'sd32767)       osat = 16'sh7fff;
    else if (tsh < -52'sd32768) osat = 16'sh8000;
    else begin
      osat  = tsh[15:0];
      oclip = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) out_valid <= 1'b0;
    else if (cmd.out_load) out_valid <= 1'b1;
    else if (!out_stall) out_valid <= 1'b0;
    if (cmd.out_load) begin
      out_sample  <= osat;
      out_channel <= ch_r;
      out_clipped <= oclip;
    end
  end

endmodule

// File: rtl/iir_band_bank_equalizer_unit.sv
// ----------------------------------------------------------------------------
// iir_band_bank_equalizer_unit
// Graphic equalizer built from a bank of direct-form-I IIR band filters.
// ----------------------------------------------------------------------------
// After reset the unit runs a clearing pass over the coefficient and history
// memories, CLR_LEN addresses long (set by the coefficient memory), before it
// takes items. An audio sample is processed band by band, tap by tap, and then
// the histories are shifted; its pace is set by the single shared
// multiply-accumulate unit and the history shift, and no new item is taken
// until it is done. The result sits in an output register; the next item is
// taken once it has been moved there, so a stalled output delays it further.
module iir_band_bank_equalizer_unit import ibeq_pkg::*; (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [1:0]         in_kind,
  input  logic [0:0]         in_channel,
  input  logic signed [15:0] in_sample,
  input  logic [3:0]         in_band,
  input  logic [2:0]         in_coef_index,
  input  logic [0:0]         in_coef_is_feedback,
  input  logic signed [23:0] in_coef_value,
  input  logic [15:0]        in_gain_value,
  output logic               out_valid,
  input  logic               out_stall,
  output logic signed [15:0] out_sample,
  output logic [0:0]         out_channel,
  output logic               out_clipped
);

  ibeq_cmd_t cmd;
  ibeq_sts_t sts;

  // hold new output until the previous transfer is done
  ibeq_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .out_busy (out_valid && out_stall),
    .sts      (sts),
    .cmd      (cmd)
  );

  ibeq_dp u_dp (
    .clk                 (clk),
    .rst_n               (rst_n),
    .cmd                 (cmd),
    .sts                 (sts),
    .in_kind             (in_kind),
    .in_channel          (in_channel),
    .in_sample           (in_sample),
    .in_band             (in_band),
    .in_coef_index       (in_coef_index),
    .in_coef_is_feedback (in_coef_is_feedback),
    .in_coef_value       (in_coef_value),
    .in_gain_value       (in_gain_value),
    .out_stall           (out_stall),
    .out_valid           (out_valid),
    .out_sample          (out_sample),
    .out_channel         (out_channel),
    .out_clipped         (out_clipped)
  );

endmodule
